### hw/rtl/wmmd_pkg.sv
// Shared types and constants of the waveform min/max decimator.
// Used by the register block, controller and datapath; no dependencies.
package wmmd_pkg;

  localparam int unsigned MAX_COLUMNS  = 4096;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned FRAME_W      = 24;
  localparam int unsigned COL_W        = 13;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned FMT_W        = 3;
  localparam int unsigned CPOS_W       = 3;
  localparam int unsigned DIV_W        = 24;

  localparam logic [1:0] REG_TOTAL_FRAMES  = 2'd0;
  localparam logic [1:0] REG_COLUMN_TOTAL  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_TOTAL = 2'd2;
  localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd3;

  localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_S32 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_F32 = 3'd3;

  typedef struct packed {
    logic [FRAME_W-1:0] total_frames;
    logic [COL_W-1:0]   column_total;
    logic [CHAN_W-1:0]  channel_total;
    logic [FMT_W-1:0]   sample_format;
  } cfg_t;

  typedef struct packed {
    logic div_start;
    logic init;
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic emit;
    logic out_stall;
    logic out_valid;
  } stat_t;

endpackage

### hw/rtl/wmmd_regs.sv
// Configuration registers of the min/max decimator behind an APB-style port.
// Depends on wmmd_pkg for the register map and the cfg_t struct.
module wmmd_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output wmmd_pkg::cfg_t      cfg,
  output logic                cfg_wr
);

  logic wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_wr = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_frames  <= 24'd1;
      cfg.column_total  <= 13'd1;
      cfg.channel_total <= 4'd1;
      cfg.sample_format <= 3'd1;
    end else if (wr) begin
      case (paddr[3:2])
        wmmd_pkg::REG_TOTAL_FRAMES:  cfg.total_frames  <= pwdata[23:0];
        wmmd_pkg::REG_COLUMN_TOTAL:  cfg.column_total  <= pwdata[12:0];
        wmmd_pkg::REG_CHANNEL_TOTAL: cfg.channel_total <= pwdata[3:0];
        wmmd_pkg::REG_SAMPLE_FORMAT: cfg.sample_format <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wmmd_pkg::REG_TOTAL_FRAMES:  prdata = {8'd0, cfg.total_frames};
      wmmd_pkg::REG_COLUMN_TOTAL:  prdata = {19'd0, cfg.column_total};
      wmmd_pkg::REG_CHANNEL_TOTAL: prdata = {28'd0, cfg.channel_total};
      wmmd_pkg::REG_SAMPLE_FORMAT: prdata = {29'd0, cfg.sample_format};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/wmmd_div.sv
// Restoring divider, one quotient bit per cycle; run on reset, cfg writes.
// Depends on wmmd_pkg for the operand width.
module wmmd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wmmd_pkg::DIV_W-1:0]    dividend,
  input  logic [wmmd_pkg::DIV_W-1:0]    divisor,
  output logic                          busy,
  output logic [wmmd_pkg::DIV_W-1:0]    quotient,
  output logic [wmmd_pkg::DIV_W-1:0]    remainder
);

  localparam int unsigned W     = wmmd_pkg::DIV_W;
  localparam int unsigned CNT_W = $clog2(W);

  logic [CNT_W-1:0] count;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic [W:0]       shifted;
  logic [W:0]       trial;

  assign shifted   = {rem, quo[W-1]};
  assign trial     = shifted - {1'b0, dvs};
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
      quo   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
      count <= count + 1'b1;
      if (count == CNT_W'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/wmmd_ctrl.sv
// Controller of the min/max decimator: divider setup, item accept, update.
// Depends on wmmd_pkg for the command and status structs.
module wmmd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  wmmd_pkg::stat_t  stat,
  output wmmd_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {ST_DIV, ST_WAIT, ST_IDLE, ST_PROC} state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.div_start = (state == ST_DIV);
    cmd.init      = (state == ST_WAIT) && !stat.div_busy;
    cmd.load      = (state == ST_IDLE) && s_tvalid;
    cmd.commit    = (state == ST_PROC) && !(stat.emit && stat.out_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_DIV:  state_next = ST_WAIT;
      ST_WAIT: if (!stat.div_busy) state_next = ST_IDLE;
      ST_IDLE: if (s_tvalid) state_next = ST_PROC;
      ST_PROC: if (cmd.commit) state_next = ST_IDLE;
      default: state_next = ST_DIV;
    endcase
    if (cfg_wr) begin
      state_next = ST_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DIV;
    end else begin
      state <= state_next;
    end
  end

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> stat.div_busy)
    else $error("divider not running after start");

  a_load_after_setup: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !stat.div_busy)
    else $error("word accepted while boundary setup still running");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && stat.emit |=> stat.out_valid)
    else $error("emitted peak pair not held in output register");

endmodule

### hw/rtl/wmmd_dp.sv
// Datapath of the min/max decimator: normalization, running min/max,
// column boundary stepper, divider and output register. Uses wmmd_pkg, wmmd_div.
module wmmd_dp (
  input  logic             clk,
  input  logic             rst,
  input  wmmd_pkg::cfg_t   cfg,
  input  wmmd_pkg::cmd_t   cmd,
  output wmmd_pkg::stat_t  stat,
  input  logic [31:0]      s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [95:0]      m_tdata,
  output logic             m_tlast
);

  localparam int unsigned FW = wmmd_pkg::FRAME_W;
  localparam int unsigned CW = wmmd_pkg::COL_W;
  localparam int unsigned PW = wmmd_pkg::CPOS_W;
  localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] norm_sample(input logic [31:0] w,
                                                      input logic [2:0] fmt);
    logic [7:0]  ex;
    logic [31:0] full;
    logic [31:0] mag;
    logic [31:0] fq;
    logic [2:0]  lsh;
    logic [4:0]  rsh;
    ex   = w[30:23];
    full = {8'd0, 1'b1, w[22:0]};
    lsh  = 3'(ex - 8'd119);
    rsh  = 5'(8'd119 - ex);
    mag  = '0;
    if (ex >= 8'd119) mag = full << lsh;
    else if (ex > 8'd95) mag = full >> rsh;
    if (ex == 8'hFF && w[22:0] != 23'd0) fq = 32'd0;
    else if (ex >= 8'd127) fq = w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else fq = w[31] ? (32'd0 - mag) : mag;
    case (fmt)
      wmmd_pkg::FMT_U8:  norm_sample = {~w[7], w[6:0], 24'd0};
      wmmd_pkg::FMT_S16: norm_sample = {w[15:0], 16'd0};
      wmmd_pkg::FMT_S32: norm_sample = w;
      wmmd_pkg::FMT_F32: norm_sample = fq;
      default:           norm_sample = 32'sd0;
    endcase
  endfunction

  logic [FW-1:0]  f_eff;
  logic [CW-1:0]  c_eff;
  logic [3:0]     ch_eff;
  logic           mode_b;
  logic [FW-1:0]  div_dividend;
  logic [FW-1:0]  div_divisor;
  logic [FW-1:0]  dq;
  logic [FW-1:0]  dr;
  logic           div_busy;

  logic signed [31:0] sample;
  logic signed [31:0] run_min;
  logic signed [31:0] run_max;
  logic signed [31:0] new_min;
  logic signed [31:0] new_max;
  logic [PW-1:0]  chan;
  logic [FW-1:0]  frame;
  logic [CW-1:0]  col;
  logic [FW-1:0]  bnd;
  logic [FW-1:0]  racc;

  logic           last_chan;
  logic           emit;
  logic [CW-1:0]  nxt_col;
  logic [CW-1:0]  run;
  logic           last;
  logic           restart;
  logic           advance;
  logic [FW-1:0]  bnd_base;
  logic [FW-1:0]  rem_base;
  logic [FW:0]    a_sum;
  logic           a_wrap;
  logic           b_wrap;
  logic           carry;
  logic [FW-1:0]  rem_step;
  logic [FW-1:0]  bnd_step;

  logic [11:0]        out_first;
  logic [CW-1:0]      out_run;
  logic signed [31:0] out_min;
  logic signed [31:0] out_max;

  always_comb begin
    f_eff = (cfg.total_frames == '0) ? FW'(1) : cfg.total_frames;
    if (cfg.column_total == '0) c_eff = CW'(1);
    else if (cfg.column_total > CW'(wmmd_pkg::MAX_COLUMNS)) c_eff = CW'(wmmd_pkg::MAX_COLUMNS);
    else c_eff = cfg.column_total;
    if (cfg.channel_total == '0) ch_eff = 4'd1;
    else if (cfg.channel_total > 4'(wmmd_pkg::MAX_CHANNELS)) ch_eff = 4'(wmmd_pkg::MAX_CHANNELS);
    else ch_eff = cfg.channel_total;
  end

  // more columns than frames: step the column boundary per frame instead
  assign mode_b       = FW'(c_eff) > f_eff;
  assign div_dividend = mode_b ? FW'(c_eff) : f_eff;
  assign div_divisor  = mode_b ? f_eff : FW'(c_eff);

  wmmd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (dq),
    .remainder (dr)
  );

  assign new_min   = (sample < run_min) ? sample : run_min;
  assign new_max   = (sample > run_max) ? sample : run_max;
  assign last_chan = ({1'b0, chan} + 4'd1) == ch_eff;
  assign emit      = last_chan && (mode_b || ((frame + 1'b1) == bnd));
  assign nxt_col   = mode_b ? bnd[CW-1:0] : (col + 1'b1);
  assign run       = nxt_col - col;
  assign last      = nxt_col >= c_eff;
  assign restart   = cmd.init || (cmd.commit && emit && last);
  assign advance   = cmd.commit && emit && !last;

  // boundary stepper: floor((c+1)F/C) or ceil((s+1)C/F) by add and compare
  always_comb begin
    bnd_base = restart ? '0 : bnd;
    rem_base = restart ? '0 : racc;
    a_sum    = {1'b0, rem_base} + {1'b0, dr};
    a_wrap   = a_sum >= {1'b0, div_divisor};
    b_wrap   = dr > rem_base;
    carry    = mode_b ? b_wrap : a_wrap;
    if (mode_b) begin
      rem_step = b_wrap ? (rem_base + div_divisor - dr) : (rem_base - dr);
    end else begin
      rem_step = a_wrap ? FW'(a_sum - {1'b0, div_divisor}) : a_sum[FW-1:0];
    end
    bnd_step = bnd_base + dq + FW'(carry);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= norm_sample(s_tdata, cfg.sample_format);
    end
    if (restart) begin
      chan    <= '0;
      frame   <= '0;
      col     <= '0;
      run_min <= Q31_MAX;
      run_max <= Q31_MIN;
      bnd     <= bnd_step;
      racc    <= rem_step;
    end else if (cmd.commit) begin
      if (!last_chan) begin
        chan    <= chan + 1'b1;
        run_min <= new_min;
        run_max <= new_max;
      end else begin
        chan  <= '0;
        frame <= frame + 1'b1;
        if (advance) begin
          col     <= nxt_col;
          run_min <= Q31_MAX;
          run_max <= Q31_MIN;
          bnd     <= bnd_step;
          racc    <= rem_step;
        end else begin
          run_min <= new_min;
          run_max <= new_max;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit) begin
      out_first <= col[11:0];
      out_run   <= run;
      out_min   <= new_min;
      out_max   <= new_max;
      m_tlast   <= last;
    end
  end

  assign m_tdata = {7'd0, out_max, out_min, out_run, out_first};

  always_comb begin
    stat           = '0;
    stat.div_busy  = div_busy;
    stat.emit      = emit;
    stat.out_stall = m_tvalid && !m_tready;
    stat.out_valid = m_tvalid;
  end

  a_peak_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_min <= out_max))
    else $error("peak pair out of order");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_run != '0))
    else $error("empty column run emitted");

endmodule

### hw/rtl/waveform_min_max_decimator.sv
// Waveform min/max decimator, top level.
// Instantiates wmmd_regs, wmmd_ctrl and wmmd_dp; types from wmmd_pkg.
//
// Samples enter on the s_axis channel, one interleaved channel word per
// transfer. Each column run of the clip yields one peak word on m_axis carrying
// first column, column run, min and max (Q1.31); tlast marks the word that
// reaches the last column, after which the next sample starts a new clip.
// The user must write registers via the APB port only while the block is idle.
// The block itself does not enforce this.
// Each sample passes an accept state, then an update state through the min/max
// compare and the column boundary stepper; the next sample is taken only after
// the update. A peak word is loaded into the output register in the update
// state of the sample that closes the column.
// After reset and after every register write the 24-step divider computes
// the boundary increments; s_axis_tready stays low until the divider is done.
// The output register lets the next sample in while a word waits; a sample
// that closes a column holds in the update cycle until the previous word
// is taken.
module waveform_min_max_decimator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // [11:0] first_column, [24:12] column_run,
                                      // [56:25] peak_min, [88:57] peak_max, zero fill
  output logic        m_axis_tlast,   // final_column
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  wmmd_pkg::cfg_t  cfg;
  wmmd_pkg::cmd_t  cmd;
  wmmd_pkg::stat_t stat;
  logic            cfg_wr;

  wmmd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  wmmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wmmd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_axis_tdata),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tlast  (m_axis_tlast)
  );

endmodule

### tb/wmmd_peak_checker.sv
// Scoreboard for the waveform min/max decimator: watches the APB, sample and peak channels.
// Predicts each peak word from the accepted samples and compares field by field.
// Depends on wmmd_pkg for the register, format and config types.
module wmmd_peak_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,   // [11:0] first_column, [24:12] column_run,
                                      // [56:25] peak_min, [88:57] peak_max
  input  logic        m_axis_tlast,   // final_column
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [11:0] first_column;
    logic [12:0] column_run;
    logic [31:0] peak_min;
    logic [31:0] peak_max;
    logic        final_column;
  } peak_word_t;

  wmmd_pkg::cfg_t     cfg;
  longint unsigned    frame_pos, chan_pos, col_pos, col_stop;
  logic signed [31:0] low_q31, high_q31;
  peak_word_t         peaks_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint unsigned frames_eff();
    return (cfg.total_frames == 0) ? 1 : cfg.total_frames;
  endfunction

  function automatic longint unsigned cols_eff();
    if (cfg.column_total == 0) return 1;
    if (cfg.column_total > wmmd_pkg::MAX_COLUMNS) return wmmd_pkg::MAX_COLUMNS;
    return cfg.column_total;
  endfunction

  function automatic longint unsigned chans_eff();
    if (cfg.channel_total == 0) return 1;
    if (cfg.channel_total > wmmd_pkg::MAX_CHANNELS) return wmmd_pkg::MAX_CHANNELS;
    return cfg.channel_total;
  endfunction

  function automatic longint unsigned col_first(longint unsigned c);
    return (c * frames_eff()) / cols_eff();
  endfunction

  function automatic longint unsigned col_stop_frame(longint unsigned c);
    longint unsigned s, e;
    s = col_first(c);
    e = ((c + 1) * frames_eff()) / cols_eff();
    if (e <= s) e = s + 1;
    return e;
  endfunction

  // columns from c on that start on the same frame as c
  function automatic longint unsigned col_share(longint unsigned c);
    longint unsigned f, n, nxt;
    f   = frames_eff();
    n   = cols_eff();
    nxt = ((col_first(c) + 1) * n + f - 1) / f;
    if (nxt > n) nxt = n;
    if (nxt <= c) return 1;
    return nxt - c;
  endfunction

  function automatic logic [31:0] to_q31(logic [31:0] w);
    logic [7:0]  ex;
    logic [31:0] mant, mag;
    int          sh;
    case (cfg.sample_format)
      wmmd_pkg::FMT_U8:  return {~w[7], w[6:0], 24'd0};
      wmmd_pkg::FMT_S16: return {w[15:0], 16'd0};
      wmmd_pkg::FMT_S32: return w;
      wmmd_pkg::FMT_F32: begin
        ex = w[30:23];
        if (ex == 8'hFF && w[22:0] != 0) return 32'd0;
        if (ex == 8'd0) return 32'd0;
        sh = int'(ex) - 119;
        if (sh >= 8) return w[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        mant = {8'd0, 1'b1, w[22:0]};
        if (sh >= 0) mag = mant << sh;
        else if (sh <= -24) mag = 32'd0;
        else mag = mant >> (-sh);
        return w[31] ? -mag : mag;
      end
      default: return 32'd0;
    endcase
  endfunction

  task automatic restart_clip();
    frame_pos = 0;
    chan_pos  = 0;
    col_pos   = 0;
    col_stop  = col_stop_frame(0);
    low_q31   = 32'sh7FFF_FFFF;
    high_q31  = 32'sh8000_0000;
  endtask

  task automatic apply_write(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      wmmd_pkg::REG_TOTAL_FRAMES:  cfg.total_frames  = data[wmmd_pkg::FRAME_W-1:0];
      wmmd_pkg::REG_COLUMN_TOTAL:  cfg.column_total  = data[wmmd_pkg::COL_W-1:0];
      wmmd_pkg::REG_CHANNEL_TOTAL: cfg.channel_total = data[wmmd_pkg::CHAN_W-1:0];
      default:                     cfg.sample_format = data[wmmd_pkg::FMT_W-1:0];
    endcase
    restart_clip();
  endtask

  task automatic take_sample(input logic [31:0] w);
    logic signed [31:0] s;
    longint unsigned    run;
    peak_word_t         pw;
    s = to_q31(w);
    if (s < low_q31) low_q31 = s;
    if (s > high_q31) high_q31 = s;
    chan_pos++;
    if (chan_pos < chans_eff()) return;
    chan_pos = 0;
    frame_pos++;
    if (frame_pos < col_stop) return;
    run             = col_share(col_pos);
    pw.first_column = col_pos[11:0];
    pw.column_run   = run[12:0];
    pw.peak_min     = low_q31;
    pw.peak_max     = high_q31;
    pw.final_column = (col_pos + run) >= cols_eff();
    peaks_due.push_back(pw);
    if (pw.final_column) begin
      restart_clip();
    end else begin
      col_pos  += run;
      col_stop  = col_stop_frame(col_pos);
      low_q31   = 32'sh7FFF_FFFF;
      high_q31  = 32'sh8000_0000;
    end
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_word();
    peak_word_t want;
    if (peaks_due.size() == 0) begin
      report_error($sformatf("peak word %h with none expected", m_axis_tdata));
      return;
    end
    want = peaks_due.pop_front();
    if (m_axis_tdata[11:0] !== want.first_column)
      report_error($sformatf("first_column got %0d expected %0d",
                             m_axis_tdata[11:0], want.first_column));
    if (m_axis_tdata[24:12] !== want.column_run)
      report_error($sformatf("column_run got %0d expected %0d",
                             m_axis_tdata[24:12], want.column_run));
    if (m_axis_tdata[56:25] !== want.peak_min)
      report_error($sformatf("peak_min got %h expected %h",
                             m_axis_tdata[56:25], want.peak_min));
    if (m_axis_tdata[88:57] !== want.peak_max)
      report_error($sformatf("peak_max got %h expected %h",
                             m_axis_tdata[88:57], want.peak_max));
    if (m_axis_tlast !== want.final_column)
      report_error($sformatf("final_column got %b expected %b",
                             m_axis_tlast, want.final_column));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{total_frames: 1, column_total: 1, channel_total: 1,
              sample_format: wmmd_pkg::FMT_S16};
      restart_clip();
      peaks_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (psel && penable && pwrite && pready) apply_write(paddr[3:2], pwdata);
      if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata);
    end
    pending = peaks_due.size();
  end

endmodule

### tb/tb_top.sv
// Top of the waveform min/max decimator testbench: clock, reset, APB setup and sample stimulus.
// Instantiates waveform_min_max_decimator and wmmd_peak_checker; types from wmmd_pkg.
module tb_top;

  localparam int          LIMIT        = 400000;
  localparam int          RANDOM_ITEMS = 1050;
  localparam logic [2:0]  FMT_ZERO_LO  = 3'd4;
  localparam logic [2:0]  FMT_ZERO_HI  = 3'd7;
  localparam logic [31:0] F32_POS_ONE  = 32'h3F80_0000;
  localparam logic [31:0] F32_NEG_ONE  = 32'hBF80_0000;
  localparam logic [31:0] F32_POS_INF  = 32'h7F80_0000;
  localparam logic [31:0] F32_NEG_INF  = 32'hFF80_0000;
  localparam logic [31:0] F32_NAN      = 32'h7FC0_0000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] sample_bits
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;   // [11:0] first_column, [24:12] column_run,
                               // [56:25] peak_min, [88:57] peak_max, zero fill
  logic        m_axis_tlast;   // final_column
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  int fail_count, pending;
  int burst_left  = 0;
  int cycle_count = 0;
  int rx_mode = 0, rx_left = 0, rx_tick = 0;
  int clip_frames, clip_chans;

  waveform_min_max_decimator i_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  wmmd_peak_checker i_check (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // peak sink: picks a new stall style whenever its random run counter expires
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(32, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (rx_tick % 7 == 0);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic send_sample(input logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = w;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    burst_left--;
  endtask

  // stop sending and let every expected peak word drain
  task automatic settle();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] keep;
    case (idx)
      wmmd_pkg::REG_TOTAL_FRAMES:  keep = 32'h00FF_FFFF;
      wmmd_pkg::REG_COLUMN_TOTAL:  keep = 32'h0000_1FFF;
      wmmd_pkg::REG_CHANNEL_TOTAL: keep = 32'h0000_000F;
      default:                     keep = 32'h0000_0007;
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = (value & keep) | (($urandom_range(0, 3) == 0) ? ($urandom & ~keep) : 32'd0);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_clip(input logic [23:0] f, input logic [12:0] c,
                          input logic [3:0] ch, input logic [2:0] fmt);
    settle();
    write_reg(wmmd_pkg::REG_TOTAL_FRAMES, 32'(f));
    write_reg(wmmd_pkg::REG_COLUMN_TOTAL, 32'(c));
    write_reg(wmmd_pkg::REG_CHANNEL_TOTAL, 32'(ch));
    write_reg(wmmd_pkg::REG_SAMPLE_FORMAT, 32'(fmt));
    clip_frames = (f == 0) ? 1 : f;
    clip_chans  = (ch == 0) ? 1 :
                  ((ch > wmmd_pkg::MAX_CHANNELS) ? wmmd_pkg::MAX_CHANNELS : ch);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4, 5:    return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 135)), 23'($urandom)};
      6:       return {24'($urandom), 8'($urandom_range(0, 1) ? 8'h00 : 8'hFF)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] s16_words[4];
    logic [31:0] u8_words[3];
    logic [31:0] f32_words[12];
    logic [23:0] f;
    logic [12:0] c;
    logic [3:0]  ch;
    logic [2:0]  fmt;
    int          sent, n, clip_len, phase_no, r;

    s16_words = '{32'h0000_7FFF, 32'hFFFF_8000, 32'h1234_0000, 32'h0000_0001};
    u8_words  = '{32'hABCD_EF00, 32'h0000_00FF, 32'h5555_5580};
    f32_words = '{F32_POS_ONE, F32_NEG_ONE, 32'h3F7F_FFFF, 32'hBF7F_FFFF,
                  F32_POS_INF, F32_NEG_INF, F32_NAN, 32'h0000_0001,
                  32'h3000_0000, 32'h2F80_0000, 32'h8000_0000,
                  32'h3F00_0000};

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst           = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset setup: one s16 frame per clip
    foreach (s16_words[k]) send_sample(s16_words[k]);

    // more columns than frames, zero channels, u8
    set_clip(24'd3, 13'd8191, 4'd0, wmmd_pkg::FMT_U8);
    foreach (u8_words[k]) send_sample(u8_words[k]);

    set_clip(24'd12, 13'd12, 4'd1, wmmd_pkg::FMT_F32);
    foreach (f32_words[k]) send_sample(f32_words[k]);

    // zero frames
    set_clip(24'd0, 13'd2, 4'd1, wmmd_pkg::FMT_S32);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);

    // zero columns, unknown format
    set_clip(24'd1, 13'd0, 4'd1, FMT_ZERO_HI);
    send_sample(32'hDEAD_BEEF);

    // widest settings, no column completes
    set_clip(24'hFF_FFFF, 13'd4096, 4'd15, wmmd_pkg::FMT_S32);
    repeat (8) send_sample(pick_sample());

    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 11);
      f = (r == 0) ? 24'd0 : (r == 1) ? 24'($urandom_range(200, 3000)) :
          (r == 2) ? 24'hFF_FFFF : 24'($urandom_range(1, 40));
      r = $urandom_range(0, 9);
      c = (r == 0) ? 13'd0 : (r == 1) ? 13'($urandom_range(4096, 8191)) :
          (r == 2) ? 13'(((f == 0) ? 1 : f) + $urandom_range(1, 60)) :
          13'($urandom_range(1, 24));
      ch = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
      r   = $urandom_range(0, 9);
      fmt = (r > 7) ? wmmd_pkg::FMT_F32 :
            ((r >= FMT_ZERO_LO && $urandom_range(0, 1)) ? wmmd_pkg::FMT_S16 : 3'(r));
      set_clip(f, c, ch, fmt);

      clip_len = clip_frames * clip_chans;
      n = clip_len * $urandom_range(1, 3);
      if (n > 200) n = $urandom_range(60, 200);
      if ($urandom_range(0, 7) == 0) n += $urandom_range(1, 2 * clip_chans);
      for (int i = 0; i < n; i++) begin
        if (i == n / 2 && phase_no % 3 == 0) settle();
        send_sample(pick_sample());
        sent++;
      end
      phase_no++;
    end

    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
